/* hdl/hdb_pkg.sv */
// Shared types, constants and helpers for the detector hit binning block.
`timescale 1ns / 1ps

package hdb_pkg;

  // Table geometry
  localparam int DET_DEPTH = 2048;
  localparam int DET_AW    = (DET_DEPTH > 1) ? $clog2(DET_DEPTH) : 1;
  localparam int DET_CW    = $clog2(DET_DEPTH + 1);

  // Field widths
  localparam int POS_W    = 24;
  localparam int ABS_W    = POS_W;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int CNT_W    = 32;
  localparam int TIME_W   = 32;
  localparam int WEIGHT_W = 16;
  localparam int CODE_W   = 20;
  localparam int RADIUS_W = 16;
  localparam int R2_W     = 2 * RADIUS_W;
  localparam int NDET_W   = 12;
  localparam int CFG_W    = 16;

  localparam int SPECIES_DIV = 1000;

  // Command codes
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_BEGIN    = 2'd1,
    OP_PARTICLE = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_DETECTORS = 1'b0,
    CFG_RADIUS    = 1'b1
  } cfg_idx_t;

  // Particle species class
  typedef enum logic [2:0] {
    SP_NONE,
    SP_POSITRON,
    SP_ELECTRON,
    SP_NEUTRAL,
    SP_MUON_PLUS,
    SP_MUON_MINUS
  } species_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_DRAIN
  } state_t;

  // Detector position entry
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } pos_rec_t;

  // Per-detector event record
  typedef struct packed {
    logic [CNT_W-1:0]  positron;
    logic [CNT_W-1:0]  electron;
    logic [CNT_W-1:0]  muon_plus;
    logic [CNT_W-1:0]  muon_minus;
    logic [TIME_W-1:0] min_time;
    logic              hit;
  } acc_rec_t;

  localparam acc_rec_t CLEAR_REC = '{
    positron:   '0,
    electron:   '0,
    muon_plus:  '0,
    muon_minus: '0,
    min_time:   '1,
    hit:        1'b0
  };

  // Walk issue toward the distance pipeline
  typedef struct packed {
    logic              valid;
    logic [DET_AW-1:0] addr;
  } dist_in_t;

  // Distance pipeline result
  typedef struct packed {
    logic              valid;
    logic [DET_AW-1:0] addr;
    logic              hit;
    logic              pending;
  } dist_out_t;

  // Species = code / 1000, decided by range compares
  function automatic species_t species_of(logic [CODE_W-1:0] code);
    species_t s;
    s = SP_NONE;
    if (code < CODE_W'(2 * SPECIES_DIV))      s = SP_NONE;
    else if (code < CODE_W'(3 * SPECIES_DIV)) s = SP_POSITRON;
    else if (code < CODE_W'(4 * SPECIES_DIV)) s = SP_ELECTRON;
    else if (code < CODE_W'(5 * SPECIES_DIV)) s = SP_NEUTRAL;
    else if (code < CODE_W'(6 * SPECIES_DIV)) s = SP_MUON_PLUS;
    else if (code < CODE_W'(7 * SPECIES_DIV)) s = SP_MUON_MINUS;
    return s;
  endfunction

endpackage

/* hdl/hdb_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module hdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/hdb_dist.sv */
// Three-stage squared-distance pipeline: abs difference, square, compare.
`timescale 1ns / 1ps

module hdb_dist (
  input  logic                           clk,
  input  logic                           rst,
  input  hdb_pkg::dist_in_t              issue,
  input  hdb_pkg::pos_rec_t              det_pos,
  input  logic signed [hdb_pkg::POS_W-1:0] part_x,
  input  logic signed [hdb_pkg::POS_W-1:0] part_y,
  input  logic [hdb_pkg::R2_W-1:0]       radius_sq,
  output hdb_pkg::dist_out_t             result
);

  logic                          s1_valid, s2_valid, s3_valid;
  logic [hdb_pkg::DET_AW-1:0]    s1_addr, s2_addr, s3_addr;
  logic [hdb_pkg::ABS_W-1:0]     abs_x, abs_y;
  logic [hdb_pkg::SQ_W-1:0]      sq_x, sq_y;
  logic                          s3_hit;
  logic signed [hdb_pkg::POS_W:0] diff_x, diff_y;
  logic [hdb_pkg::DIST_W-1:0]    dist_sq;

  // Signed differences, one bit wider than the coordinates
  assign diff_x = {part_x[hdb_pkg::POS_W-1], part_x} - {det_pos.x[hdb_pkg::POS_W-1], det_pos.x};
  assign diff_y = {part_y[hdb_pkg::POS_W-1], part_y} - {det_pos.y[hdb_pkg::POS_W-1], det_pos.y};
  assign dist_sq = hdb_pkg::DIST_W'(sq_x) + hdb_pkg::DIST_W'(sq_y);

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Stage 1: magnitudes of the differences
  always_ff @(posedge clk) begin
    s1_addr <= issue.addr;
    abs_x   <= hdb_pkg::ABS_W'(diff_x[hdb_pkg::POS_W] ? -diff_x : diff_x);
    abs_y   <= hdb_pkg::ABS_W'(diff_y[hdb_pkg::POS_W] ? -diff_y : diff_y);
  end

  // Stage 2: squares
  always_ff @(posedge clk) begin
    s2_addr <= s1_addr;
    sq_x    <= hdb_pkg::SQ_W'(abs_x) * hdb_pkg::SQ_W'(abs_x);
    sq_y    <= hdb_pkg::SQ_W'(abs_y) * hdb_pkg::SQ_W'(abs_y);
  end

  // Stage 3: compare against radius squared
  always_ff @(posedge clk) begin
    s3_addr <= s2_addr;
    s3_hit  <= (dist_sq <= hdb_pkg::DIST_W'(radius_sq));
  end

  assign result.valid   = s3_valid;
  assign result.addr    = s3_addr;
  assign result.hit     = s3_hit;
  assign result.pending = issue.valid | s1_valid | s2_valid | s3_valid;

endmodule

/* hdl/hdb_accum.sv */
// Record update for one hit: saturating weight add and earliest-time keep.
`timescale 1ns / 1ps

module hdb_accum (
  input  hdb_pkg::acc_rec_t              rec_in,
  input  hdb_pkg::species_t              species,
  input  logic [hdb_pkg::WEIGHT_W-1:0]   weight,
  input  logic [hdb_pkg::TIME_W-1:0]     arrival,
  output hdb_pkg::acc_rec_t              rec_out
);

  logic [hdb_pkg::CNT_W:0]   sum_sel;
  logic [hdb_pkg::CNT_W-1:0] sel_cnt;
  logic [hdb_pkg::CNT_W-1:0] sat_cnt;

  // Pick the counter for this species
  always_comb begin
    case (species)
      hdb_pkg::SP_POSITRON:   sel_cnt = rec_in.positron;
      hdb_pkg::SP_ELECTRON:   sel_cnt = rec_in.electron;
      hdb_pkg::SP_MUON_PLUS:  sel_cnt = rec_in.muon_plus;
      hdb_pkg::SP_MUON_MINUS: sel_cnt = rec_in.muon_minus;
      default:                sel_cnt = '0;
    endcase
  end

  // Saturating add
  assign sum_sel = {1'b0, sel_cnt} + (hdb_pkg::CNT_W + 1)'(weight);
  assign sat_cnt = sum_sel[hdb_pkg::CNT_W] ? '1 : sum_sel[hdb_pkg::CNT_W-1:0];

  // Build the updated record
  always_comb begin
    rec_out     = rec_in;
    rec_out.hit = 1'b1;
    if (arrival < rec_in.min_time) begin
      rec_out.min_time = arrival;
    end
    case (species)
      hdb_pkg::SP_POSITRON:   rec_out.positron   = sat_cnt;
      hdb_pkg::SP_ELECTRON:   rec_out.electron   = sat_cnt;
      hdb_pkg::SP_MUON_PLUS:  rec_out.muon_plus  = sat_cnt;
      hdb_pkg::SP_MUON_MINUS: rec_out.muon_minus = sat_cnt;
      default:                ;
    endcase
  end

endmodule

/* hdl/particle_detector_hit_binning.sv */
// Top level of the detector hit binning block: sequencer, memories, read port.
`timescale 1ns / 1ps

// Detector hit binning.
// Commands enter on start/operation while busy is low; each transfer is one
// command. Load detector writes one position entry. Begin event sweeps the
// record memory, one entry per cycle, and holds busy until the sweep is done.
// A particle of species 2 to 6 walks the position table, one detector per
// cycle through a five-deep read/distance/update pipeline, and holds busy
// until min(detectors_in_use, 2048) detectors are walked and the pipeline,
// with any last hit write-back, has drained; other species leave busy low.
// The detector walk rate is set by the single position table read port. Read
// detector shows its result on the total ports with result_valid high for
// exactly one cycle, the cycle after acceptance.
// The receiver cannot stall; results must be taken when result_valid is high.
// The user must write configuration (cfg_we/cfg_index/cfg_data) only while
// busy is low; the block itself does not enforce this.
// After rst the block clears all detector records with busy high;
// configuration writes are taken during that sweep.
module particle_detector_hit_binning (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [hdb_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         operation,
  input  logic [10:0]                        detector_index,
  input  logic signed [hdb_pkg::POS_W-1:0]   pos_x_cm,
  input  logic signed [hdb_pkg::POS_W-1:0]   pos_y_cm,
  input  logic [hdb_pkg::CODE_W-1:0]         particle_code,
  input  logic [hdb_pkg::TIME_W-1:0]         arrival_time,
  input  logic [hdb_pkg::WEIGHT_W-1:0]       weight,
  output logic                               result_valid,
  output logic [hdb_pkg::CNT_W-1:0]          positron_total,
  output logic [hdb_pkg::CNT_W-1:0]          electron_total,
  output logic [hdb_pkg::CNT_W-1:0]          muon_plus_total,
  output logic [hdb_pkg::CNT_W-1:0]          muon_minus_total,
  output logic [hdb_pkg::TIME_W-1:0]         earliest_time,
  output logic                               was_hit
);

  hdb_pkg::state_t   state, state_next;
  hdb_pkg::op_t      op;
  hdb_pkg::species_t in_species;
  hdb_pkg::dist_in_t  dist_issue;
  hdb_pkg::dist_out_t dist_res;
  hdb_pkg::pos_rec_t  pos_wdata, pos_rdata;
  hdb_pkg::acc_rec_t  acc_wdata, acc_rdata, acc_upd;

  logic [hdb_pkg::NDET_W-1:0]     detectors_in_use;
  logic [hdb_pkg::RADIUS_W-1:0]   radius_cm;

  logic                           accept;
  logic                           idx_in_range;
  logic                           particle_go;
  logic                           walk_issue;
  logic                           clear_we;
  logic                           walk_done;
  logic                           clear_done;
  logic [hdb_pkg::DET_CW-1:0]     cnt;
  logic [hdb_pkg::DET_CW-1:0]     walk_limit;
  logic [hdb_pkg::DET_CW-1:0]     limit_next;
  logic [hdb_pkg::DET_AW-1:0]     idx_addr;

  logic signed [hdb_pkg::POS_W-1:0] part_x, part_y;
  hdb_pkg::species_t                part_species;
  logic [hdb_pkg::TIME_W-1:0]       part_time;
  logic [hdb_pkg::WEIGHT_W-1:0]     part_weight;
  logic [hdb_pkg::R2_W-1:0]         radius_sq;

  logic                           iss_valid;
  logic [hdb_pkg::DET_AW-1:0]     iss_addr;
  logic                           wb_valid;
  logic [hdb_pkg::DET_AW-1:0]     wb_addr;
  logic                           pos_we;
  logic                           acc_we;
  logic [hdb_pkg::DET_AW-1:0]     acc_waddr;
  logic [hdb_pkg::DET_AW-1:0]     acc_raddr;
  logic                           rd_pend;
  logic                           rd_in_range;

  // Command decode
  assign op           = hdb_pkg::op_t'(operation);
  assign accept       = start && !busy;
  assign in_species   = hdb_pkg::species_of(particle_code);
  assign idx_in_range = int'(detector_index) < hdb_pkg::DET_DEPTH;
  assign idx_addr     = hdb_pkg::DET_AW'(detector_index);
  assign particle_go  = accept && (op == hdb_pkg::OP_PARTICLE) && (in_species != hdb_pkg::SP_NONE);
  assign limit_next   = (int'(detectors_in_use) > hdb_pkg::DET_DEPTH) ?
                        hdb_pkg::DET_CW'(hdb_pkg::DET_DEPTH) : hdb_pkg::DET_CW'(detectors_in_use);
  assign walk_done    = (cnt == walk_limit);
  assign clear_done   = (cnt == hdb_pkg::DET_CW'(hdb_pkg::DET_DEPTH - 1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      detectors_in_use <= hdb_pkg::NDET_W'(1636);
      radius_cm        <= hdb_pkg::RADIUS_W'(180);
    end else if (cfg_we) begin
      unique case (hdb_pkg::cfg_idx_t'(cfg_index))
        hdb_pkg::CFG_DETECTORS: detectors_in_use <= cfg_data[hdb_pkg::NDET_W-1:0];
        hdb_pkg::CFG_RADIUS:    radius_cm        <= cfg_data[hdb_pkg::RADIUS_W-1:0];
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      hdb_pkg::ST_IDLE: begin
        if (accept && (op == hdb_pkg::OP_BEGIN)) state_next = hdb_pkg::ST_CLEAR;
        else if (particle_go) state_next = hdb_pkg::ST_WALK;
      end
      hdb_pkg::ST_CLEAR: begin
        if (clear_done) state_next = hdb_pkg::ST_IDLE;
      end
      hdb_pkg::ST_WALK: begin
        if (walk_done) state_next = hdb_pkg::ST_DRAIN;
      end
      hdb_pkg::ST_DRAIN: begin
        if (!iss_valid && !dist_res.pending && !wb_valid) state_next = hdb_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    busy       = 1'b1;
    walk_issue = 1'b0;
    clear_we   = 1'b0;
    unique case (state)
      hdb_pkg::ST_IDLE:  busy = 1'b0;
      hdb_pkg::ST_CLEAR: clear_we = 1'b1;
      hdb_pkg::ST_WALK:  walk_issue = !walk_done;
      hdb_pkg::ST_DRAIN: ;
    endcase
  end

  // State register and control pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hdb_pkg::ST_CLEAR;
      iss_valid <= 1'b0;
      wb_valid  <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      iss_valid <= walk_issue;
      wb_valid  <= dist_res.valid && dist_res.hit;
      rd_pend   <= accept && (op == hdb_pkg::OP_READ);
    end
  end

  // Walk and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (clear_we || walk_issue) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Latch the particle for the walk
  always_ff @(posedge clk) begin
    if (particle_go) begin
      part_x       <= pos_x_cm;
      part_y       <= pos_y_cm;
      part_species <= in_species;
      part_time    <= arrival_time;
      part_weight  <= weight;
      radius_sq    <= hdb_pkg::R2_W'(radius_cm) * hdb_pkg::R2_W'(radius_cm);
      walk_limit   <= limit_next;
    end
  end

  // Address pipeline alongside the memory reads
  always_ff @(posedge clk) begin
    iss_addr    <= cnt[hdb_pkg::DET_AW-1:0];
    wb_addr     <= dist_res.addr;
    rd_in_range <= idx_in_range;
  end

  // Position table
  assign pos_we      = accept && (op == hdb_pkg::OP_LOAD) && idx_in_range;
  assign pos_wdata.x = pos_x_cm;
  assign pos_wdata.y = pos_y_cm;

  hdb_ram #(
    .WIDTH ($bits(hdb_pkg::pos_rec_t)),
    .DEPTH (hdb_pkg::DET_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (idx_addr),
    .wdata (pos_wdata),
    .raddr (cnt[hdb_pkg::DET_AW-1:0]),
    .rdata (pos_rdata)
  );

  // Distance pipeline
  assign dist_issue.valid = iss_valid;
  assign dist_issue.addr  = iss_addr;

  hdb_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .issue     (dist_issue),
    .det_pos   (pos_rdata),
    .part_x    (part_x),
    .part_y    (part_y),
    .radius_sq (radius_sq),
    .result    (dist_res)
  );

  // Record update
  hdb_accum u_accum (
    .rec_in  (acc_rdata),
    .species (part_species),
    .weight  (part_weight),
    .arrival (part_time),
    .rec_out (acc_upd)
  );

  // Record memory: clear sweep or hit write-back; read for walk or command
  assign acc_we    = clear_we || wb_valid;
  assign acc_waddr = clear_we ? cnt[hdb_pkg::DET_AW-1:0] : wb_addr;
  assign acc_wdata = clear_we ? hdb_pkg::CLEAR_REC : acc_upd;
  assign acc_raddr = (state == hdb_pkg::ST_IDLE) ? idx_addr : dist_res.addr;

  hdb_ram #(
    .WIDTH ($bits(hdb_pkg::acc_rec_t)),
    .DEPTH (hdb_pkg::DET_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Read result
  assign result_valid     = rd_pend;
  assign positron_total   = rd_in_range ? acc_rdata.positron   : '0;
  assign electron_total   = rd_in_range ? acc_rdata.electron   : '0;
  assign muon_plus_total  = rd_in_range ? acc_rdata.muon_plus  : '0;
  assign muon_minus_total = rd_in_range ? acc_rdata.muon_minus : '0;
  assign was_hit          = rd_in_range && acc_rdata.hit;
  assign earliest_time    = was_hit ? acc_rdata.min_time : '0;

`ifndef NO_ASSERTIONS
  // A result appears only in the cycle after a read transfer
  a_result_after_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && (operation == hdb_pkg::OP_READ)))
    else $error("result without a read transfer");

  // Position table is never written during a walk
  a_no_load_when_busy: assert property (@(posedge clk) disable iff (rst)
    pos_we |-> (state == hdb_pkg::ST_IDLE))
    else $error("position write while busy");

  // Record memory is only written by the sweep or a walk
  a_acc_write_owner: assert property (@(posedge clk) disable iff (rst)
    acc_we |-> (state == hdb_pkg::ST_CLEAR || state == hdb_pkg::ST_WALK ||
                state == hdb_pkg::ST_DRAIN))
    else $error("record write while idle");

  // Leaving reset starts the clearing sweep
  a_busy_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

  // Walk write-back only follows a hit from the distance pipeline
  a_wb_from_hit: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> $past(dist_res.valid && dist_res.hit))
    else $error("write-back without hit");
`endif

endmodule

/* bench/particle_detector_hit_binning_test.sv */
// Self-checking bench for the detector hit binning block: command driver and tally predictor.
`timescale 1ns / 1ps

module particle_detector_hit_binning_test;
  import hdb_pkg::*;

  localparam int TABLE_DEPTH = DET_DEPTH;
  localparam int LOADED      = 64;
  localparam int GRID_PITCH  = 400;
  localparam int MAX_SPAN    = 70000;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
  localparam logic [TIME_W-1:0]   LATEST_TIME = '1;
  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = '1;

  // Species numbers as code / 1000
  localparam int SPECIES_POSITRON   = 2;
  localparam int SPECIES_ELECTRON   = 3;
  localparam int SPECIES_NEUTRAL    = 4;
  localparam int SPECIES_MUON_PLUS  = 5;
  localparam int SPECIES_MUON_MINUS = 6;

  typedef struct {
    op_t                     op;
    logic [10:0]             index;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [CODE_W-1:0]       code;
    logic [TIME_W-1:0]       stamp;
    logic [WEIGHT_W-1:0]     weight;
  } hit_cmd_t;

  typedef struct {
    logic [CNT_W-1:0]  positron;
    logic [CNT_W-1:0]  electron;
    logic [CNT_W-1:0]  muon_plus;
    logic [CNT_W-1:0]  muon_minus;
    logic [TIME_W-1:0] earliest;
    logic              hit;
  } readout_t;

  // Detector tally predictor and store of expected readouts
  class hit_tally_board;
    int                det_x [TABLE_DEPTH];
    int                det_y [TABLE_DEPTH];
    logic [CNT_W-1:0]  pos_cnt [TABLE_DEPTH];
    logic [CNT_W-1:0]  ele_cnt [TABLE_DEPTH];
    logic [CNT_W-1:0]  mup_cnt [TABLE_DEPTH];
    logic [CNT_W-1:0]  mum_cnt [TABLE_DEPTH];
    logic [TIME_W-1:0] first_time [TABLE_DEPTH];
    bit                hit_seen [TABLE_DEPTH];
    int unsigned       walk_count;
    int unsigned       radius;
    readout_t          pending_readouts[$];
    int                errors;
    int                readouts_checked;
    int                particles_walked;

    function new();
      walk_count = 1636;
      radius     = 180;
      clear_tallies();
    endfunction

    function void clear_tallies();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        pos_cnt[i]    = '0;
        ele_cnt[i]    = '0;
        mup_cnt[i]    = '0;
        mum_cnt[i]    = '0;
        first_time[i] = '1;
        hit_seen[i]   = 1'b0;
      end
    endfunction

    function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [WEIGHT_W-1:0] b);
      longint unsigned total;
      total = 64'(a) + 64'(b);
      return (total > 64'hFFFF_FFFF) ? '1 : total[CNT_W-1:0];
    endfunction

    function void write_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
      if (idx == CFG_DETECTORS) begin
        walk_count = 32'(value[NDET_W-1:0]);
      end else begin
        radius = 32'(value);
      end
    endfunction

    // Update the tallies for one accepted command; queue a readout on a read
    function void note_command(hit_cmd_t c);
      int unsigned     species;
      int unsigned     span;
      longint unsigned r2;
      longint unsigned range_sq;
      longint          dx;
      longint          dy;
      readout_t        r;
      case (c.op)
        OP_LOAD: begin
          det_x[c.index] = int'(c.x);
          det_y[c.index] = int'(c.y);
        end
        OP_BEGIN: clear_tallies();
        OP_PARTICLE: begin
          species = c.code / SPECIES_DIV;
          if (species >= SPECIES_POSITRON && species <= SPECIES_MUON_MINUS) begin
            particles_walked++;
            span = (walk_count > TABLE_DEPTH) ? TABLE_DEPTH : walk_count;
            r2 = 64'(radius) * 64'(radius);
            for (int i = 0; i < span; i++) begin
              dx = longint'(c.x) - longint'(det_x[i]);
              dy = longint'(c.y) - longint'(det_y[i]);
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              range_sq = dx * dx + dy * dy;
              if (range_sq <= r2) begin
                case (species)
                  SPECIES_POSITRON:   pos_cnt[i] = sat_add(pos_cnt[i], c.weight);
                  SPECIES_ELECTRON:   ele_cnt[i] = sat_add(ele_cnt[i], c.weight);
                  SPECIES_MUON_PLUS:  mup_cnt[i] = sat_add(mup_cnt[i], c.weight);
                  SPECIES_MUON_MINUS: mum_cnt[i] = sat_add(mum_cnt[i], c.weight);
                  default: ;
                endcase
                if (c.stamp < first_time[i]) first_time[i] = c.stamp;
                hit_seen[i] = 1'b1;
              end
            end
          end
        end
        default: begin
          r.positron   = pos_cnt[c.index];
          r.electron   = ele_cnt[c.index];
          r.muon_plus  = mup_cnt[c.index];
          r.muon_minus = mum_cnt[c.index];
          r.earliest   = hit_seen[c.index] ? first_time[c.index] : '0;
          r.hit        = hit_seen[c.index];
          pending_readouts.push_back(r);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Match one readout against the oldest expectation
    function void check_readout(readout_t got);
      readout_t want;
      if (pending_readouts.size() == 0) begin
        $display("%0t: readout with nothing expected, positron_total %0d",
                 $time, got.positron);
        errors++;
        return;
      end
      want = pending_readouts.pop_front();
      readouts_checked++;
      compare_field("positron_total", want.positron, got.positron);
      compare_field("electron_total", want.electron, got.electron);
      compare_field("muon_plus_total", want.muon_plus, got.muon_plus);
      compare_field("muon_minus_total", want.muon_minus, got.muon_minus);
      compare_field("earliest_time", want.earliest, got.earliest);
      compare_field("was_hit", 32'(want.hit), 32'(got.hit));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic                    cfg_index = 1'b0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              operation = '0;
  logic [10:0]             detector_index = '0;
  logic signed [POS_W-1:0] pos_x_cm = '0;
  logic signed [POS_W-1:0] pos_y_cm = '0;
  logic [CODE_W-1:0]       particle_code = '0;
  logic [TIME_W-1:0]       arrival_time = '0;
  logic [WEIGHT_W-1:0]     weight = '0;
  logic                    result_valid;
  logic [CNT_W-1:0]        positron_total;
  logic [CNT_W-1:0]        electron_total;
  logic [CNT_W-1:0]        muon_plus_total;
  logic [CNT_W-1:0]        muon_minus_total;
  logic [TIME_W-1:0]       earliest_time;
  logic                    was_hit;

  hit_tally_board tally;
  int unsigned    sender_idle_pct;

  particle_detector_hit_binning dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .operation        (operation),
    .detector_index   (detector_index),
    .pos_x_cm         (pos_x_cm),
    .pos_y_cm         (pos_y_cm),
    .particle_code    (particle_code),
    .arrival_time     (arrival_time),
    .weight           (weight),
    .result_valid     (result_valid),
    .positron_total   (positron_total),
    .electron_total   (electron_total),
    .muon_plus_total  (muon_plus_total),
    .muon_minus_total (muon_minus_total),
    .earliest_time    (earliest_time),
    .was_hit          (was_hit)
  );

  always #5 clk = ~clk;

  // Check readouts first, then record the command transferred at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        tally.check_readout('{positron_total, electron_total, muon_plus_total,
                              muon_minus_total, earliest_time, was_hit});
      end
      if (start && !busy) begin
        tally.note_command('{op_t'(operation), detector_index, pos_x_cm, pos_y_cm,
                             particle_code, arrival_time, weight});
      end
    end
  end

  // Guard against a hung handshake
  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Detectors sit on an 8-wide grid around the origin
  function automatic int grid_x(int i);
    return (i % 8) * GRID_PITCH - 1600;
  endfunction

  function automatic int grid_y(int i);
    return (i / 8) * GRID_PITCH - 1600;
  endfunction

  function automatic logic signed [POS_W-1:0] to_pos(int v);
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v[POS_W-1:0];
  endfunction

  function automatic hit_cmd_t make_cmd(op_t op, logic [10:0] index,
                                        logic signed [POS_W-1:0] x,
                                        logic signed [POS_W-1:0] y,
                                        logic [CODE_W-1:0] code,
                                        logic [TIME_W-1:0] stamp,
                                        logic [WEIGHT_W-1:0] w);
    hit_cmd_t c;
    c.op     = op;
    c.index  = index;
    c.x      = x;
    c.y      = y;
    c.code   = code;
    c.stamp  = stamp;
    c.weight = w;
    return c;
  endfunction

  // Present one command after a random gap and hold it until transferred
  task automatic send_command(input hit_cmd_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    operation      <= c.op;
    detector_index <= c.index;
    pos_x_cm       <= c.x;
    pos_y_cm       <= c.y;
    particle_code  <= c.code;
    arrival_time   <= c.stamp;
    weight         <= c.weight;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every readout is in and the last walk has finished
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (tally.pending_readouts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // One register write, then cfg_we is dropped and the tally model is updated
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tally.write_register(idx, value);
    @(posedge clk);
  endtask

  // Random mix: half particles, mostly aimed near a walked detector, plus reads, loads, clears
  task automatic run_random_phase(input int unsigned count);
    hit_cmd_t    c;
    int unsigned roll;
    int unsigned reach;
    int unsigned target;
    int unsigned span;
    for (int k = 0; k < count; k++) begin
      reach = (tally.walk_count == 0) ? LOADED : tally.walk_count;
      target = $urandom_range(reach - 1);
      c = make_cmd(OP_READ, 11'($urandom), POS_W'($urandom), POS_W'($urandom),
                   CODE_W'($urandom_range(999999)), $urandom, WEIGHT_W'($urandom));
      if ($urandom_range(9) == 0) c.weight = $urandom_range(1) ? FULL_WEIGHT : '0;
      if ($urandom_range(9) == 0) c.stamp = $urandom_range(1) ? LATEST_TIME : '0;
      roll = $urandom_range(99);
      if (roll < 15) begin
        c.op = OP_LOAD;
        if ($urandom_range(3) != 0) begin
          c.x = to_pos(grid_x(int'(c.index)) + int'($urandom_range(100)) - 50);
          c.y = to_pos(grid_y(int'(c.index)) + int'($urandom_range(100)) - 50);
        end
      end else if (roll < 23) begin
        c.op = OP_BEGIN;
      end else if (roll < 73) begin
        c.op = OP_PARTICLE;
        if ($urandom_range(9) != 0) begin
          c.code = CODE_W'($urandom_range(SPECIES_MUON_MINUS, SPECIES_POSITRON) * SPECIES_DIV
                           + $urandom_range(SPECIES_DIV - 1));
        end
        if ($urandom_range(9) < 8) begin
          span = (tally.radius + 20 > MAX_SPAN) ? MAX_SPAN : tally.radius + 20;
          c.x = clamp_pos(longint'(tally.det_x[target]) + longint'($urandom_range(2 * span))
                          - longint'(span));
          c.y = clamp_pos(longint'(tally.det_y[target]) + longint'($urandom_range(2 * span))
                          - longint'(span));
        end
      end else begin
        if ($urandom_range(3) != 0) c.index = 11'(target);
      end
      send_command(c);
    end
  endtask

  initial begin
    int d5x;
    int d5y;
    tally = new();
    sender_idle_pct = 34;
    d5x = grid_x(5);
    d5y = grid_y(5);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait out the clearing sweep, then walk only the loaded entries
    settle();
    write_register(CFG_DETECTORS, 16'(LOADED));
    for (int i = 0; i < LOADED; i++) begin
      send_command(make_cmd(OP_LOAD, 11'(i), to_pos(grid_x(i)), to_pos(grid_y(i)),
                            CODE_W'($urandom), $urandom, WEIGHT_W'($urandom)));
    end

    // Directed: corner positions, each species, radius boundary, latest time
    send_command(make_cmd(OP_LOAD, 1, POS_MIN, POS_MIN, 0, 0, 0));
    send_command(make_cmd(OP_LOAD, 2, POS_MAX, POS_MAX, 0, 0, 0));
    send_command(make_cmd(OP_LOAD, 3, POS_MAX, POS_MIN, 0, 0, 0));
    send_command(make_cmd(OP_BEGIN, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 5, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x), to_pos(d5y), 2000,
                          LATEST_TIME, FULL_WEIGHT));
    send_command(make_cmd(OP_READ, 5, 0, 0, 0, 0, 0));
    // Exactly on the capture radius (108, 144 -> 180)
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x + 108), to_pos(d5y + 144),
                          3999, 100, 0));
    // Neutral species: hit and time only
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x), to_pos(d5y - 180), 4000, 50, 7));
    // Just outside the radius
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x + 181), to_pos(d5y), 5500, 10, 9));
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x - 100), to_pos(d5y + 100),
                          6999, 0, 1234));
    // Species outside 2 to 6 leave everything alone
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x), to_pos(d5y), 1999, 1, FULL_WEIGHT));
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x), to_pos(d5y), 7000, 1, FULL_WEIGHT));
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x), to_pos(d5y), 0, 1, FULL_WEIGHT));
    send_command(make_cmd(OP_PARTICLE, 0, to_pos(d5x), to_pos(d5y), 999999, 1,
                          FULL_WEIGHT));
    send_command(make_cmd(OP_READ, 5, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_PARTICLE, 0, POS_MAX, POS_MIN, 5000, 77, FULL_WEIGHT));
    send_command(make_cmd(OP_PARTICLE, 0, POS_MIN, POS_MAX, 2999, 3, 5));
    send_command(make_cmd(OP_READ, 3, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_LOAD, 11'(LOADED - 1), POS_MIN, POS_MAX, 0, 0, 0));
    send_command(make_cmd(OP_READ, 11'(LOADED - 1), 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 2047, 0, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));

    // Random phases across table lengths and radii
    run_random_phase(28);
    settle();
    write_register(CFG_DETECTORS, 0);
    write_register(CFG_RADIUS, 16'hFFFF);
    run_random_phase(28);

    sender_idle_pct = 74;
    settle();
    // Upper data bits are dropped, leaving a table length of 32
    write_register(CFG_DETECTORS, 16'hF020);
    write_register(CFG_RADIUS, 180);
    run_random_phase(28);
    settle();
    write_register(CFG_DETECTORS, 40);
    write_register(CFG_RADIUS, 0);
    run_random_phase(28);
    settle();
    write_register(CFG_DETECTORS, 16'(LOADED));
    write_register(CFG_RADIUS, 400);
    run_random_phase(28);

    sender_idle_pct = 0;
    settle();
    write_register(CFG_DETECTORS, 16'(LOADED));
    write_register(CFG_RADIUS, 16'hFFFF);
    run_random_phase(28);
    settle();
    write_register(CFG_DETECTORS, 1);
    write_register(CFG_RADIUS, 1);
    run_random_phase(28);

    settle();
    repeat (20) @(posedge clk);
    if (tally.pending_readouts.size() != 0) begin
      $display("%0t: %0d readouts never arrived", $time, tally.pending_readouts.size());
    end
    $display("Run: %0d particle walks, %0d readouts checked, table lengths 0 to %0d,",
             tally.particles_walked, tally.readouts_checked, LOADED);
    $display("radius 0 to 65535, corner positions, boundary hits and every species.");
    if (tally.errors == 0 && tally.pending_readouts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
